[hw/rtl/sfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame demultiplexer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 16;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] HEAD_RST = 8'hAA;
    localparam logic [7:0] TAIL_RST = 8'h55;
    localparam logic [7:0] KEPT_RST = 8'h11;

    localparam logic [1:0] REG_HEAD = 2'd0;
    localparam logic [1:0] REG_TAIL = 2'd1;
    localparam logic [1:0] REG_KEPT = 2'd2;

    localparam logic KIND_PASS  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] tail;
        logic [7:0] kept;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_word;

endpackage

[hw/rtl/sfd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_front
// Accepts bytes, holds the frame window, checks tail and type, and sequences
// frame output and false-head re-scans into the word queue.
// ----------------------------------------------------------------------------
module sfd_front
    import sfd_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    output logic       o_s_ready,
    input  logic [7:0] i_s_byte,
    input  t_cfg       i_cfg,
    output logic       o_push,
    output t_word      o_word,
    input  logic       i_full
);

    localparam int unsigned AW = $clog2(FRAME_BYTES);
    localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
    localparam logic [AW:0]   N_A      = (AW + 1)'(FRAME_BYTES);
    localparam logic [CW-1:0] N_C      = CW'(FRAME_BYTES);
    localparam logic [CW-1:0] HELD_TOP = CW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PROC, S_TYPE, S_EMIT, S_SCAN, S_FLUSH
    } t_state;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] k);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, k};
        if (s >= N_A) begin
            s = s - N_A;
        end
        return s[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [7:0]    r_byte, n_byte;
    logic [AW-1:0] r_base, n_base;
    logic [CW-1:0] r_held, n_held;
    logic [AW-1:0] r_idx, n_idx;
    logic [7:0]    r_pend, n_pend;
    logic          r_pend_vld, n_pend_vld;

    logic [7:0]    r_mem [FRAME_BYTES];
    logic [7:0]    r_rd_data;
    logic          w_we, w_re;
    logic [AW-1:0] w_wa, w_ra;

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_base     = r_base;
        n_held     = r_held;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        o_push     = 1'b0;
        o_word     = '0;
        w_we       = 1'b0;
        w_wa       = r_base;
        w_re       = 1'b0;
        w_ra       = r_base;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_byte  = i_s_byte;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (r_held == '0) begin
                    if (r_byte != i_cfg.head) begin
                        if (!i_full) begin
                            o_push  = 1'b1;
                            o_word  = '{kind: KIND_PASS, data: r_byte, last: 1'b1};
                            n_state = S_IDLE;
                        end
                    end else begin
                        w_we    = 1'b1;
                        n_held  = CW'(1);
                        n_state = S_IDLE;
                    end
                end else begin
                    w_we = 1'b1;
                    w_wa = wrap_add(r_base, r_held[AW-1:0]);
                    if (r_held != HELD_TOP) begin
                        n_held  = r_held + CW'(1);
                        n_state = S_IDLE;
                    end else begin
                        n_held = '0;
                        w_re   = 1'b1;
                        w_ra   = wrap_add(r_base, AW'(1));
                        if (r_byte == i_cfg.tail) begin
                            n_state = S_TYPE;
                        end else begin
                            n_idx      = AW'(1);
                            n_pend_vld = 1'b0;
                            n_state    = S_SCAN;
                        end
                    end
                end
            end
            S_TYPE: begin
                if (r_rd_data == i_cfg.kept) begin
                    w_re    = 1'b1;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    o_word = '{kind: KIND_FRAME, data: r_rd_data,
                               last: (r_idx == LAST_IDX)};
                    if (r_idx == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                        w_re  = 1'b1;
                        w_ra  = wrap_add(r_base, n_idx);
                    end
                end
            end
            S_SCAN: begin
                if (!r_pend_vld || !i_full) begin
                    if (r_rd_data == i_cfg.head) begin
                        if (r_pend_vld) begin
                            o_push = 1'b1;
                            o_word = '{kind: KIND_PASS, data: r_pend, last: 1'b1};
                        end
                        n_pend_vld = 1'b0;
                        n_base     = wrap_add(r_base, r_idx);
                        n_held     = N_C - CW'(r_idx);
                        n_state    = S_IDLE;
                    end else begin
                        if (r_pend_vld) begin
                            o_push = 1'b1;
                            o_word = '{kind: KIND_PASS, data: r_pend, last: 1'b0};
                        end
                        n_pend     = r_rd_data;
                        n_pend_vld = 1'b1;
                        if (r_idx == LAST_IDX) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx = r_idx + AW'(1);
                            w_re  = 1'b1;
                            w_ra  = wrap_add(r_base, n_idx);
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (!i_full) begin
                    o_push     = 1'b1;
                    o_word     = '{kind: KIND_PASS, data: r_pend, last: 1'b1};
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_base     <= '0;
            r_held     <= '0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_held     <= n_held;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
        end
        r_byte <= n_byte;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= r_byte;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

endmodule

[hw/rtl/sfd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_queue
// Small word queue between the front sequencer and the output stage.
// ----------------------------------------------------------------------------
module sfd_queue
    import sfd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    output logic  o_full,
    input  logic  i_pop,
    output t_word o_word,
    output logic  o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_TOP = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_TOP = CW'(DEPTH);

    t_word         r_buf [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_TOP);
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_TOP) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_TOP) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_push) begin
            r_buf[r_wp] <= i_word;
        end
    end

endmodule

[hw/rtl/sfd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_back
// Output register stage: pulls words from the queue onto the master stream.
// ----------------------------------------------------------------------------
module sfd_back
    import sfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_word      i_word,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tuser,
    output logic       o_m_tlast
);

    logic  r_vld;
    t_word r_word;

    assign o_pop      = !i_empty && (!r_vld || i_m_tready);
    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_word.data;
    assign o_m_tuser  = r_word.kind;
    assign o_m_tlast  = r_word.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_vld <= 1'b0;
        end
        if (o_pop) begin
            r_word <= i_word;
        end
    end

endmodule

[hw/rtl/serial_frame_demultiplexer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_demultiplexer_top
// Splits a received byte stream into passthrough bytes and fixed-length
// head/tail frames of the selected type.
// Flow: a kept frame streams 1 word per cycle while the queue is not full;
//   the front takes no new byte while it processes one, and holds longer
//   for a frame end or false-head re-scan.
// Reset: synchronous, active low; clears control and registers, not window.
// ----------------------------------------------------------------------------
module serial_frame_demultiplexer_top
    import sfd_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tuser,   // [0] kind
    output logic        o_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    t_cfg  r_cfg;
    logic  w_wr;
    logic  w_push, w_full, w_pop, w_empty;
    t_word w_front_word, w_queue_word;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{head: HEAD_RST, tail: TAIL_RST, kept: KEPT_RST};
        end else if (w_wr) begin
            unique case (i_paddr[3:2])
                REG_HEAD: r_cfg.head <= i_pwdata[7:0];
                REG_TAIL: r_cfg.tail <= i_pwdata[7:0];
                REG_KEPT: r_cfg.kept <= i_pwdata[7:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            REG_HEAD: o_prdata = {24'd0, r_cfg.head};
            REG_TAIL: o_prdata = {24'd0, r_cfg.tail};
            REG_KEPT: o_prdata = {24'd0, r_cfg.kept};
            default:  o_prdata = '0;
        endcase
    end

    sfd_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(i_s_tvalid),
        .o_s_ready(o_s_tready),
        .i_s_byte (i_s_tdata),
        .i_cfg    (r_cfg),
        .o_push   (w_push),
        .o_word   (w_front_word),
        .i_full   (w_full)
    );

    sfd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_word (w_front_word),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_word (w_queue_word),
        .o_empty(w_empty)
    );

    sfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (w_queue_word),
        .i_empty   (w_empty),
        .o_pop     (w_pop),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("word pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("word popped from empty queue");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("front took a word while busy");

endmodule

[tb/sv/serial_frame_demultiplexer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_demultiplexer_top_tb
// Streams serial bytes into the demultiplexer and checks every output word
// against an in-bench frame sync predictor. Covers passthrough bytes, kept and
// dropped frames, false heads with re-scan, and register changes while a
// partial frame is held. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module serial_frame_demultiplexer_top_tb;
    import sfd_pkg::*;

    localparam int unsigned FB = FRAME_BYTES_DEF;

    class frame_scoreboard;
        logic [7:0]  head;
        logic [7:0]  tail;
        logic [7:0]  kept;
        logic [7:0]  window [FB];
        int unsigned held;
        t_word       expected_q [$];
        int unsigned errors;

        function void clear();
            head   = HEAD_RST;
            tail   = TAIL_RST;
            kept   = KEPT_RST;
            held   = 0;
            errors = 0;
            expected_q.delete();
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                REG_HEAD: head = v;
                REG_TAIL: tail = v;
                REG_KEPT: kept = v;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void expect_word(logic k, logic [7:0] d, logic l);
            t_word w;
            w.kind = k;
            w.data = d;
            w.last = l;
            expected_q.push_back(w);
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned i;
            int unsigned j;
            if (held == 0) begin
                if (b != head) begin
                    expect_word(KIND_PASS, b, 1'b1);
                end else begin
                    window[0] = b;
                    held = 1;
                end
                return;
            end
            window[held] = b;
            held++;
            if (held < FB) return;
            held = 0;
            if (window[FB - 1] == tail) begin
                if (window[1] == kept) begin
                    for (i = 0; i < FB; i++) expect_word(KIND_FRAME, window[i], i == FB - 1);
                end
                return;
            end
            // false head: drop it, pass bytes up to the next head, resume there
            i = 1;
            while (i < FB && window[i] != head) i++;
            for (j = 1; j < i; j++) expect_word(KIND_PASS, window[j], j == i - 1);
            if (i < FB) begin
                for (j = 0; j < FB - i; j++) window[j] = window[j + i];
                held = FB - i;
            end
        endfunction

        function void check_word(t_word got);
            t_word want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: kind=%0d byte=%h last=%0d",
                             got.kind, got.data, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected kind=%0d byte=%h last=%0d, got kind=%0d byte=%h last=%0d",
                             want.kind, want.data, want.last, got.kind, got.data, got.last);
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_psel     = 1'b0;
    logic        i_penable  = 1'b0;
    logic        i_pwrite   = 1'b0;
    logic [3:0]  i_paddr    = '0;
    logic [31:0] i_pwdata   = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    frame_scoreboard sb;
    bit              steady = 1'b0;
    int unsigned     bytes_sent = 0;

    serial_frame_demultiplexer_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output side: check accepted words, stall at random
    always @(posedge i_clk) begin
        t_word got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = o_m_tuser;
            got.data = o_m_tdata;
            got.last = o_m_tlast;
            sb.check_word(got);
        end
        i_m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= {24'h0, v};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_reg(idx, v);
    endtask

    task automatic apply_cfg(input logic [7:0] h, input logic [7:0] t, input logic [7:0] k);
        write_reg(REG_HEAD, h);
        write_reg(REG_TAIL, t);
        write_reg(REG_KEPT, k);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 30) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // mostly frames with random content, some broken, some plain noise
    task automatic send_burst();
        logic [7:0]  fr [FB];
        int unsigned cut;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            return;
        end
        repeat ($urandom_range(2)) send_byte(8'($urandom));
        fr[0] = sb.head;
        fr[1] = ($urandom_range(99) < 70) ? sb.kept : 8'($urandom);
        for (int i = 2; i < FB - 1; i++) fr[i] = 8'($urandom);
        if ($urandom_range(99) < 25) fr[$urandom_range(FB - 2, 1)] = sb.head;
        fr[FB - 1] = ($urandom_range(99) < 75) ? sb.tail : 8'($urandom);
        cut = ($urandom_range(99) < 10) ? $urandom_range(FB - 1, 1) : FB;
        for (int i = 0; i < cut; i++) send_byte(fr[i]);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (FB + 8) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]  body [13];
        int unsigned start;
        body = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hAA,
                 8'h55, 8'h11, 8'h02, 8'h40, 8'hBF, 8'hFD};
        sb = new;
        sb.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_cfg(HEAD_RST, TAIL_RST, KEPT_RST);
                1: apply_cfg(8'h00, 8'hFF, 8'hFF);
                2: apply_cfg(8'hFF, 8'h00, 8'h00);
                3: apply_cfg(8'($urandom), 8'($urandom), 8'($urandom));
                default: apply_cfg(8'h5A, 8'h5A, 8'h5A);
            endcase
            if (p == 0) begin
                send_byte(8'h00);
                send_byte(8'hFF);
                send_byte(HEAD_RST);
                send_byte(KEPT_RST);
                foreach (body[i]) send_byte(body[i]);
                send_byte(TAIL_RST);
            end
            steady = (p == 2);
            start = bytes_sent;
            while (bytes_sent - start < 80) send_burst();
            // leave a partial frame held across the next register change
            send_byte(sb.head);
            repeat (5) send_byte(8'($urandom));
            drain();
        end

        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0d expected words never arrived", sb.pending());
        end
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
